### design/laf_pkg.sv
// Shared types, constants and codes for the label area filter.
`timescale 1ns / 1ps

package laf_pkg;

  localparam int NUM_LABELS = 32768;
  localparam int AREA_BITS  = 24;

  localparam int ADDR_W  = $clog2(NUM_LABELS);
  localparam int LABEL_W = 15;
  localparam int CNT_W   = 15;
  localparam int LIMIT_W = 24;
  localparam int CFG_W   = 24;
  // Wide enough for label and NUM_LABELS itself at any legal depth.
  localparam int LEXT_W  = ADDR_W + 2;
  // Wide enough for area + 1 and limit + 1 without overflow.
  localparam int CMP_W   = ((AREA_BITS > LIMIT_W) ? AREA_BITS : LIMIT_W) + 2;

  localparam logic [AREA_BITS-1:0] AREA_MAX   = '1;
  localparam logic [ADDR_W-1:0]    ADDR_LAST  = ADDR_W'(NUM_LABELS - 1);
  localparam logic [LIMIT_W-1:0]   LIMIT_RST  = LIMIT_W'(5);
  localparam logic [LABEL_W-1:0]   FIRST_REGION = LABEL_W'(2);

  typedef enum logic [1:0] {
    OP_COUNT    = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_REPORT   = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic {
    CFG_REMOVE_BIG = 1'b0,
    CFG_SIZE_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    CLR_IDLE = 1'b0,
    CLR_RUN  = 1'b1
  } clr_state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [LABEL_W-1:0] label;
  } in_item_t;

  typedef struct packed {
    logic               mask;
    logic [CNT_W-1:0]   regions_in;
    logic [CNT_W-1:0]   regions_kept;
    logic               area_saturated;
  } out_item_t;

  typedef struct packed {
    logic              busy;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
  } clr_status_t;

endpackage

### design/laf_area_ram.sv
// Area table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module laf_area_ram
  import laf_pkg::*;
(
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [AREA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [AREA_BITS-1:0] rd_data
);

  logic [AREA_BITS-1:0] mem [NUM_LABELS];
  logic [AREA_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/laf_clear_seq.sv
// Clear sequencer: walks the area table writing zero, one entry per cycle.
`timescale 1ns / 1ps

module laf_clear_seq
  import laf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output clr_status_t status
);

  clr_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CLR_IDLE: if (start) state_nxt = CLR_RUN;
      CLR_RUN:  if (ptr_r == ADDR_LAST) state_nxt = CLR_IDLE;
      default:  state_nxt = CLR_IDLE;
    endcase
  end

  always_comb begin
    status.busy  = 1'b0;
    status.wr_en = 1'b0;
    status.addr  = ptr_r;
    ptr_nxt      = '0;
    case (state_r)
      CLR_RUN: begin
        status.busy  = 1'b1;
        status.wr_en = 1'b1;
        ptr_nxt      = ptr_r + ADDR_W'(1);
      end
      default: ptr_nxt = '0;
    endcase
  end

  // Reset starts a full sweep so the table comes up zeroed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CLR_RUN;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

endmodule

### design/label_area_filter_unit.sv
// Top level: label area histogram and classifier around the area table memory.
//
//   channel | dir | payload     | handshake
//   --------+-----+-------------+------------------------------
//   in_     | in  | in_item_t   | in_valid / in_stall
//   out_    | out | out_item_t  | out_valid / out_stall
//   cfg_    | in  | cfg_wdata   | cfg_we, cfg_index (no read-back)
//
// One item per cycle while in_stall is low: the table read is issued at
// the input transfer, the read-modify-write completes the next cycle, with
// forwarding for back to back hits on one label. A result leaves stage 1
// through the output register. After reset, and after each clear item,
// the NUM_LABELS (32768) entries are zeroed while in_stall stays high.
// out_stall back-pressures through the output register into in_stall.
`timescale 1ns / 1ps

module label_area_filter_unit
  import laf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // Configuration
  logic               remove_big_r;
  logic [LIMIT_W-1:0] size_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remove_big_r <= 1'b0;
      size_limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REMOVE_BIG: remove_big_r <= cfg_wdata[0];
        CFG_SIZE_LIMIT: size_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input decode
  logic [LEXT_W-1:0] in_lext;
  logic [ADDR_W-1:0] in_addr;
  logic              in_lvalid;
  logic              in_accept;

  assign in_lext   = LEXT_W'(in_item.label);
  assign in_addr   = in_lext[ADDR_W-1:0];
  assign in_lvalid = in_lext < LEXT_W'(NUM_LABELS);

  // Stage 1 registers
  logic              s1_v_r;
  logic [1:0]        s1_op_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_lvalid_r;
  logic              s1_lge2_r;
  logic              s1_lnz_r;
  logic                 fwd_hit_r;
  logic [AREA_BITS-1:0] fwd_data_r;

  logic [AREA_BITS-1:0] rd_data;
  logic [AREA_BITS-1:0] area;
  logic [AREA_BITS-1:0] area_nxt;
  logic                 s1_res;
  logic                 s1_go;
  logic                 s1_wr;
  logic                 clr_start;
  clr_status_t          clr;

  logic [CNT_W-1:0] used_cnt_r, used_cnt_nxt;
  logic [CNT_W-1:0] above_cnt_r, above_cnt_nxt;
  logic             out_v_r;
  out_item_t        out_item_r;

  // Take the value written last cycle when the read missed it.
  assign area     = fwd_hit_r ? fwd_data_r : rd_data;
  assign area_nxt = area + AREA_BITS'(1);

  assign s1_res = s1_v_r && (s1_op_r inside {OP_CLASSIFY, OP_REPORT});
  assign s1_go  = !s1_res || !out_v_r || !out_stall;
  assign s1_wr  = s1_v_r && s1_go && (s1_op_r == OP_COUNT) && s1_lvalid_r &&
                  (area != AREA_MAX);
  assign clr_start = s1_v_r && (s1_op_r == OP_CLEAR);

  // Hold input while sweeping, while stage 1 is blocked, and behind a clear.
  assign in_stall  = clr.busy || (s1_v_r && (!s1_go || (s1_op_r == OP_CLEAR)));
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r     <= in_item.op;
      s1_addr_r   <= in_addr;
      s1_lvalid_r <= in_lvalid;
      s1_lge2_r   <= in_item.label >= FIRST_REGION;
      s1_lnz_r    <= in_item.label != '0;
      fwd_hit_r   <= s1_wr && (s1_addr_r == in_addr);
      fwd_data_r  <= area_nxt;
    end
  end

  laf_area_ram u_ram (
    .clk     (clk),
    .wr_en   (clr.wr_en || s1_wr),
    .wr_addr (clr.wr_en ? clr.addr : s1_addr_r),
    .wr_data (clr.wr_en ? '0 : area_nxt),
    .rd_en   (in_accept),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  laf_clear_seq u_clr (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (clr_start),
    .status (clr)
  );

  // Running region counts
  logic [CMP_W-1:0] area_ext;
  logic [CMP_W-1:0] limit_ext;

  assign area_ext  = CMP_W'(area);
  assign limit_ext = CMP_W'(size_limit_r);

  always_comb begin
    used_cnt_nxt  = used_cnt_r;
    above_cnt_nxt = above_cnt_r;
    if (clr_start) begin
      used_cnt_nxt  = '0;
      above_cnt_nxt = '0;
    end else if (s1_wr && s1_lge2_r) begin
      if (area == '0) used_cnt_nxt = used_cnt_r + CNT_W'(1);
      if (area_ext == limit_ext) above_cnt_nxt = above_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_cnt_r  <= '0;
      above_cnt_r <= '0;
    end else begin
      used_cnt_r  <= used_cnt_nxt;
      above_cnt_r <= above_cnt_nxt;
    end
  end

  // Result
  logic      above;
  logic      keep;
  logic      classify_ok;
  out_item_t res;

  assign above       = area_ext > limit_ext;
  assign keep        = remove_big_r ? !above : above;
  assign classify_ok = (s1_op_r == OP_CLASSIFY) && s1_lvalid_r;

  always_comb begin
    res.mask           = classify_ok && s1_lnz_r && keep;
    res.regions_in     = used_cnt_r;
    res.regions_kept   = remove_big_r ? (used_cnt_r - above_cnt_r) : above_cnt_r;
    res.area_saturated = classify_ok && (area == AREA_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_res && s1_go) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_res && s1_go) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule
